/* design/prrts_pkg.sv */
package prrts_pkg;

  // Task status codes as kept in the task table.
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_BLOCKED = 2'd1;
  localparam logic [1:0] ST_TERM    = 2'd2;
  localparam logic [1:0] ST_RUN     = 2'd3;

  // Event codes on the func field.
  localparam logic [2:0] FN_ADD    = 3'd0;
  localparam logic [2:0] FN_TICK   = 3'd1;
  localparam logic [2:0] FN_YIELD  = 3'd2;
  localparam logic [2:0] FN_SLEEP  = 3'd3;
  localparam logic [2:0] FN_SET    = 3'd4;
  localparam logic [2:0] FN_STATS  = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PREEMPT = 2'd0;
  localparam logic [1:0] CFG_PERIOD  = 2'd1;
  localparam logic [1:0] CFG_SLICE   = 2'd2;

  localparam int MS_W = 20;
  localparam int PER_W = 16;

  // One row of the task table.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [63:0] wake;
    logic [31:0] run;
    logic [31:0] ready;
  } entry_t;

endpackage

/* design/priority_round_robin_task_scheduler.sv */
// One event is in work at a time: in_stall is high outside the idle state, and the next
// beat is taken once the result has been registered. A sleep of a running task passes
// through the serial divider, and a tick scans the whole table and, on a rotation, scans
// it again to pick the next task. A result still held by out_stall keeps the next event
// in its final state until it is taken.
// Synchronous active-high reset resets counters, task count, current task and configuration.
module priority_round_robin_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [3:0]  task_index,
  input  logic [7:0]  new_priority,
  input  logic [1:0]  new_status,
  input  logic [19:0] sleep_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  running_task,
  output logic        running_valid,
  output logic        switched,
  output logic        all_done,
  output logic        accepted,
  output logic [31:0] stat_run_ticks,
  output logic [31:0] stat_ready_ticks,
  output logic [63:0] tick_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import prrts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_TK_RD  = 4'd2;
  localparam logic [3:0] S_TK_WR  = 4'd3;
  localparam logic [3:0] S_PRE    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_RMW_RD = 4'd6;
  localparam logic [3:0] S_RMW_WR = 4'd7;
  localparam logic [3:0] S_ROT    = 4'd8;
  localparam logic [3:0] S_DISP   = 4'd9;
  localparam logic [3:0] S_CH_RD  = 4'd10;
  localparam logic [3:0] S_CH_EV  = 4'd11;
  localparam logic [3:0] S_CH_END = 4'd12;
  localparam logic [3:0] S_FIN    = 4'd13;

  // Task table and its registered read port.
  entry_t mem [MAX_TASKS];
  entry_t rd_data;
  logic [IW-1:0] mem_ra;
  logic [IW-1:0] mem_wa;
  entry_t mem_wd;
  logic mem_we;

  logic [3:0] state;
  logic [2:0] ev_func;
  logic [3:0] ev_idx;
  logic [7:0] ev_prio;
  logic [1:0] ev_nst;
  logic [19:0] ev_ms;
  logic ev_acc;
  logic was_run;
  logic [IW-1:0] was_task;

  logic preempt;
  logic [15:0] period;
  logic [15:0] slice;

  logic [CW-1:0] count;
  logic [CW-1:0] active;
  logic [IW-1:0] cur;
  logic cur_valid;
  logic running;
  logic [63:0] tick_counter;
  logic [15:0] slice_counter;

  logic [CW-1:0] scan_idx;
  logic [IW-1:0] rmw_addr;
  logic [1:0] rmw_status;
  logic rmw_set_wake;
  logic [63:0] rmw_wake;
  logic rmw_stats;
  logic [3:0] rmw_ret;
  logic [31:0] st_run;
  logic [31:0] st_ready;

  logic ch_rot;
  logic [IW-1:0] ch_start;
  logic ch_found;
  logic [7:0] ch_prio;
  logic [CW:0] ch_dist;
  logic [IW-1:0] ch_idx;

  logic div_start;
  logic div_done;
  logic [19:0] div_q;

  logic [IW-1:0] scan_i;
  logic [IW+3:0] idx_wide;
  logic [IW-1:0] idx_mem;
  logic idx_ok;
  logic [IW+3:0] cur_wide;
  logic [IW-1:0] start_next;
  entry_t tk_e;
  entry_t rmw_e;
  logic ch_cand;
  logic [CW:0] ch_d;
  logic ch_better;
  logic [15:0] slice_inc;
  logic [15:0] slice_eff;
  logic [19:0] sleep_t;
  logic now_run;

  assign scan_i = scan_idx[IW-1:0];
  assign idx_wide = {{IW{1'b0}}, ev_idx};
  assign idx_mem = idx_wide[IW-1:0];
  assign idx_ok = {{CW{1'b0}}, ev_idx} < {4'b0, count};
  assign cur_wide = {4'b0, cur};
  assign start_next = ({1'b0, cur} + 1'b1 == {1'b0, count}) ? '0 : cur + 1'b1;
  assign slice_inc = (slice_counter == 16'hFFFF) ? slice_counter : slice_counter + 16'd1;
  assign slice_eff = (slice == 16'd0) ? 16'd1 : slice;
  assign sleep_t = (div_q == 20'd0) ? 20'd1 : div_q;
  assign now_run = running;

  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  prrts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ev_ms),
    .divisor  (period),
    .done     (div_done),
    .quotient (div_q)
  );

  // Tick update of one table row.
  always_comb begin
    tk_e = rd_data;
    case (rd_data.status)
      ST_RUN: begin
        if (rd_data.run != 32'hFFFFFFFF) tk_e.run = rd_data.run + 32'd1;
      end
      ST_READY: begin
        if (rd_data.ready != 32'hFFFFFFFF) tk_e.ready = rd_data.ready + 32'd1;
      end
      ST_BLOCKED: begin
        if (rd_data.wake != 64'd0 && tick_counter >= rd_data.wake) begin
          tk_e.wake = 64'd0;
          tk_e.status = ST_READY;
        end
      end
      default: tk_e = rd_data;
    endcase
  end

  // Status or wake change of one addressed row.
  always_comb begin
    rmw_e = rd_data;
    if (!rmw_stats) begin
      rmw_e.status = rmw_status;
      if (rmw_set_wake) rmw_e.wake = rmw_wake;
    end
  end

  // Candidate ranking: priority first, then distance from the round-robin start.
  always_comb begin
    ch_cand = (rd_data.status == ST_READY) || (ch_rot && scan_i == cur);
    if (scan_i >= ch_start) begin
      ch_d = (CW + 1)'(scan_i) - (CW + 1)'(ch_start);
    end else begin
      ch_d = (CW + 1)'(scan_i) + (CW + 1)'(count) - (CW + 1)'(ch_start);
    end
    ch_better = ch_cand && (!ch_found || rd_data.prio > ch_prio ||
                (rd_data.prio == ch_prio && ch_d < ch_dist));
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = scan_i;
    mem_wd = tk_e;
    mem_ra = scan_i;
    if (state == S_RMW_RD) mem_ra = rmw_addr;
    case (state)
      S_DEC: begin
        if (ev_func == FN_ADD && count < CW'(MAX_TASKS)) begin
          mem_we = 1'b1;
          mem_wa = count[IW-1:0];
          mem_wd = '{status: ST_READY, prio: ev_prio, wake: 64'd0, run: 32'd0,
                     ready: 32'd0};
        end
      end
      S_TK_WR: mem_we = 1'b1;
      S_RMW_WR: begin
        mem_we = 1'b1;
        mem_wa = rmw_addr;
        mem_wd = rmw_e;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      preempt <= 1'b0;
      period <= 16'd1;
      slice <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PREEMPT: preempt <= cfg_data[0];
        CFG_PERIOD: period <= cfg_data;
        CFG_SLICE: slice <= cfg_data;
        default: preempt <= preempt;
      endcase
    end
  end

  // Event sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      active <= '0;
      cur <= '0;
      cur_valid <= 1'b0;
      running <= 1'b0;
      tick_counter <= 64'd0;
      slice_counter <= 16'd0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // The divider starts right after decoding a sleep of a running task.
      div_start <= (state == S_DEC) && (ev_func == FN_SLEEP) && (ev_ms != 20'd0) &&
                   running;
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ev_func <= func;
            ev_idx <= task_index;
            ev_prio <= new_priority;
            ev_nst <= new_status;
            ev_ms <= sleep_ms;
            ev_acc <= 1'b1;
            was_run <= running;
            was_task <= cur;
            st_run <= 32'd0;
            st_ready <= 32'd0;
            rmw_set_wake <= 1'b0;
            rmw_stats <= 1'b0;
            rmw_ret <= S_DISP;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          case (ev_func)
            FN_ADD: begin
              state <= S_DISP;
              if (count < CW'(MAX_TASKS)) begin
                count <= count + 1'b1;
                active <= active + 1'b1;
              end else begin
                ev_acc <= 1'b0;
              end
            end
            FN_TICK: begin
              tick_counter <= tick_counter + 64'd1;
              scan_idx <= '0;
              state <= S_TK_RD;
            end
            FN_YIELD: begin
              if (running) begin
                running <= 1'b0;
                rmw_addr <= cur;
                rmw_status <= ST_READY;
                state <= S_RMW_RD;
              end else begin
                state <= S_DISP;
              end
            end
            FN_SLEEP: begin
              if (ev_ms != 20'd0 && running) state <= S_DIV;
              else state <= S_DISP;
            end
            FN_SET: begin
              if (idx_ok && ev_nst != ST_RUN) begin
                if (cur_valid && idx_mem == cur) running <= 1'b0;
                rmw_addr <= idx_mem;
                rmw_status <= ev_nst;
                state <= S_RMW_RD;
              end else begin
                ev_acc <= 1'b0;
                state <= S_DISP;
              end
            end
            FN_STATS: begin
              if (idx_ok) begin
                rmw_addr <= idx_mem;
                rmw_stats <= 1'b1;
                state <= S_RMW_RD;
              end else begin
                ev_acc <= 1'b0;
                state <= S_DISP;
              end
            end
            default: begin
              ev_acc <= 1'b0;
              state <= S_DISP;
            end
          endcase
        end
        S_TK_RD: begin
          if (scan_idx == count) state <= S_PRE;
          else state <= S_TK_WR;
        end
        S_TK_WR: begin
          scan_idx <= scan_idx + 1'b1;
          state <= S_TK_RD;
        end
        S_PRE: begin
          if (preempt && running && slice_inc >= slice_eff) begin
            slice_counter <= 16'd0;
            ch_rot <= 1'b1;
            ch_start <= start_next;
            ch_found <= 1'b0;
            scan_idx <= '0;
            state <= S_CH_RD;
          end else begin
            if (preempt && running) slice_counter <= slice_inc;
            state <= S_DISP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            running <= 1'b0;
            rmw_addr <= cur;
            rmw_status <= ST_BLOCKED;
            rmw_set_wake <= 1'b1;
            rmw_wake <= tick_counter + {44'd0, sleep_t};
            state <= S_RMW_RD;
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          if (rmw_stats) begin
            st_run <= rd_data.run;
            st_ready <= rd_data.ready;
          end else if (rd_data.status == ST_TERM && rmw_status != ST_TERM) begin
            active <= active + 1'b1;
          end else if (rd_data.status != ST_TERM && rmw_status == ST_TERM) begin
            active <= active - 1'b1;
          end
          rmw_set_wake <= 1'b0;
          rmw_stats <= 1'b0;
          state <= rmw_ret;
        end
        S_ROT: begin
          // Second half of a slice rotation: the chosen task starts running.
          rmw_addr <= ch_idx;
          rmw_status <= ST_RUN;
          rmw_ret <= S_DISP;
          cur <= ch_idx;
          state <= S_RMW_RD;
        end
        S_DISP: begin
          if (running) begin
            state <= S_FIN;
          end else if (active == '0) begin
            cur_valid <= 1'b0;
            cur <= '0;
            state <= S_FIN;
          end else begin
            ch_rot <= 1'b0;
            ch_start <= cur_valid ? start_next : '0;
            ch_found <= 1'b0;
            scan_idx <= '0;
            state <= S_CH_RD;
          end
        end
        S_CH_RD: begin
          if (scan_idx == count) state <= S_CH_END;
          else state <= S_CH_EV;
        end
        S_CH_EV: begin
          if (ch_better) begin
            ch_found <= 1'b1;
            ch_prio <= rd_data.prio;
            ch_dist <= ch_d;
            ch_idx <= scan_i;
          end
          scan_idx <= scan_idx + 1'b1;
          state <= S_CH_RD;
        end
        S_CH_END: begin
          if (ch_rot) begin
            if (ch_idx != cur) begin
              rmw_addr <= cur;
              rmw_status <= ST_READY;
              rmw_ret <= S_ROT;
              state <= S_RMW_RD;
            end else begin
              state <= S_DISP;
            end
          end else if (ch_found) begin
            cur <= ch_idx;
            cur_valid <= 1'b1;
            running <= 1'b1;
            rmw_addr <= ch_idx;
            rmw_status <= ST_RUN;
            rmw_ret <= S_FIN;
            state <= S_RMW_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            running_task <= now_run ? cur_wide[3:0] : 4'd0;
            running_valid <= now_run;
            switched <= (now_run != was_run) || (now_run && cur != was_task);
            all_done <= (active == '0);
            accepted <= ev_acc;
            stat_run_ticks <= st_run;
            stat_ready_ticks <= st_ready;
            tick_now <= tick_counter;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/prrts_div.sv */
module prrts_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [prrts_pkg::MS_W-1:0]  dividend,
  input  logic [prrts_pkg::PER_W-1:0] divisor,
  output logic                         done,
  output logic [prrts_pkg::MS_W-1:0]  quotient
);
  import prrts_pkg::*;

  logic [PER_W:0]   rem;
  logic [MS_W-1:0]  shf;
  logic [PER_W-1:0] dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic [PER_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem[PER_W-1:0], shf[MS_W-1]};
  assign fits = trial >= {1'b0, dvs};
  assign quotient = shf;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        rem <= '0;
        shf <= dividend;
        dvs <= (divisor == '0) ? PER_W'(1) : divisor;
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, dvs}) : trial;
        shf <= {shf[MS_W-2:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(MS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
